[hw/rtl/lagrange_prolongation_3d_macros.svh]
// Assertion macros for the prolongation block.
// Depends on a clock i_clk and an active-low reset i_rst_n in the using module.
`ifndef LAGRANGE_PROLONGATION_3D_MACROS_SVH
`define LAGRANGE_PROLONGATION_3D_MACROS_SVH

// check that holds at every clock edge out of reset
`define LP3_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check that a signal is stable in the cycle after a condition
`define LP3_HOLD(lbl, cond, sig, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> $stable(sig)) else $error(msg);

`endif

[hw/rtl/lp3_pkg.sv]
// Shared types, constants and weight table of the 3D prolongation block.
// No dependencies.
package lp3_pkg;
    localparam int MAX_INTERIOR = 16;
    localparam int MAX_GHOST    = 4;
    localparam int MAX_SIDE     = MAX_INTERIOR + 2 * MAX_GHOST;
    localparam int RING_PLANES  = 5;
    localparam int PLANE_SIZE   = MAX_SIDE * MAX_SIDE;
    localparam int RING_DEPTH   = RING_PLANES * PLANE_SIZE;
    localparam int ADDR_W       = $clog2(RING_DEPTH);
    localparam int POS_W        = $clog2(MAX_SIDE + 1);
    localparam int SLOT_W       = $clog2(RING_PLANES);
    localparam int TAP_W        = 3;
    localparam int LAST_TAP     = 4;
    localparam int CHILDREN     = 8;
    localparam int CHILD_W      = 4;
    localparam int ACC_W        = 68;

    localparam logic [1:0] REG_INTERIOR = 2'd0;
    localparam logic [1:0] REG_GHOST    = 2'd1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DRAIN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] wr_addr;
        logic [31:0]       wdata;
        logic              re;
        logic [ADDR_W-1:0] rd_addr;
    } t_ring_req;

    function automatic logic signed [11:0] lp3_weight(logic odd, logic [TAP_W-1:0] idx);
        logic [TAP_W-1:0] k;
        logic signed [11:0] w;
        k = odd ? (TAP_W'(LAST_TAP) - idx) : idx;
        case (k)
            3'd0:    w = -12'sd45;
            3'd1:    w = 12'sd420;
            3'd2:    w = 12'sd1890;
            3'd3:    w = -12'sd252;
            3'd4:    w = 12'sd35;
            default: w = 12'sd0;
        endcase
        return w;
    endfunction
endpackage

[hw/rtl/lagrange_prolongation_3d.sv]
// Fourth-order Lagrange prolongation, 3D: top level with sequencer and MAC pipeline.
// An interior-center cell holds off the next input through 125 ring reads, the pipeline
// drain, 8 output transfers (each can be held by i_stall) and the return to idle.
// Other cells do not hold off the next input. The single ring read port sets this.
// Synchronous active-low reset clears control and sets config to its defaults (interior 8, ghost 2);
// the ring memory is not cleared. Depends on lp3_pkg, lp3_ring_mem and the macros header.
`include "lagrange_prolongation_3d_macros.svh"
module lagrange_prolongation_3d
    import lp3_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_coarse_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_fine_value,
    output logic [5:0]  o_fine_x,
    output logic [5:0]  o_fine_y,
    output logic [5:0]  o_fine_z,
    output logic        o_last_child
);
    t_state r_state, n_state;

    logic [4:0] r_cfg_n;
    logic [2:0] r_cfg_g;
    logic [POS_W-1:0] r_px, r_py, r_pz;
    logic [SLOT_W-1:0] r_slot;
    logic [POS_W-1:0] r_cx, r_cy, r_cz;
    logic [SLOT_W-1:0] r_cslot;
    logic [TAP_W-1:0] r_si, r_sj, r_sk;

    logic [POS_W-1:0] cn, cg, side, ex, ey, ez;
    logic accept, center, last_tap, rd_en, load_out;
    t_ring_req req;
    logic [31:0] rd_data;

    always_comb begin
        cn = (r_cfg_n == 5'd0) ? POS_W'(1) :
             (r_cfg_n > 5'(MAX_INTERIOR)) ? POS_W'(MAX_INTERIOR) : POS_W'(r_cfg_n);
        cg = (r_cfg_g < 3'd2) ? POS_W'(2) :
             (r_cfg_g > 3'(MAX_GHOST)) ? POS_W'(MAX_GHOST) : POS_W'(r_cfg_g);
        side = cn + (cg << 1);
    end

    logic out_of_cube;
    assign out_of_cube = (r_px >= side) || (r_py >= side) || (r_pz >= side);
    assign ex = out_of_cube ? '0 : r_px;
    assign ey = out_of_cube ? '0 : r_py;
    assign ez = out_of_cube ? '0 : r_pz;
    logic [SLOT_W-1:0] eslot;
    assign eslot = out_of_cube ? '0 : r_slot;

    assign accept = i_valid && !o_stall;
    assign center = (ex >= cg + 2) && (ex < cg + cn + 2) && (ey >= cg + 2) &&
                    (ey < cg + cn + 2) && (ez >= cg + 2) && (ez < cg + cn + 2);
    assign last_tap = (r_si == TAP_W'(LAST_TAP)) && (r_sj == TAP_W'(LAST_TAP)) &&
                      (r_sk == TAP_W'(LAST_TAP));

    logic r_v1, r_v2, r_v3, r_v4;
    logic [CHILD_W-1:0] r_child;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept && center) n_state = S_READ;
            S_READ:  if (last_tap) n_state = S_DRAIN;
            S_DRAIN: if (!r_v1 && !r_v2 && !r_v3 && !r_v4) n_state = S_EMIT;
            S_EMIT:  if (r_child == CHILD_W'(CHILDREN)) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_stall = (r_state != S_IDLE);
        rd_en   = (r_state == S_READ);
    end

    // ring addressing
    logic [SLOT_W+TAP_W-1:0] slot_sum;
    logic [SLOT_W-1:0] rslot;
    logic [POS_W-1:0] rx, ry;
    assign slot_sum = (SLOT_W+TAP_W)'(r_cslot) + (SLOT_W+TAP_W)'(r_sk) + 1'b1;
    assign rslot = (slot_sum >= (SLOT_W+TAP_W)'(RING_PLANES)) ?
                   SLOT_W'(slot_sum - (SLOT_W+TAP_W)'(RING_PLANES)) : SLOT_W'(slot_sum);
    assign rx = r_cx - POS_W'(4) + POS_W'(r_si);
    assign ry = r_cy - POS_W'(4) + POS_W'(r_sj);

    always_comb begin
        req.we      = accept;
        req.wr_addr = ADDR_W'(eslot) * ADDR_W'(PLANE_SIZE) + ADDR_W'(ey) * ADDR_W'(MAX_SIDE)
                      + ADDR_W'(ex);
        req.wdata   = i_coarse_value;
        req.re      = rd_en;
        req.rd_addr = ADDR_W'(rslot) * ADDR_W'(PLANE_SIZE) + ADDR_W'(ry) * ADDR_W'(MAX_SIDE)
                      + ADDR_W'(rx);
    end

    lp3_ring_mem u_ring (
        .i_clk     (i_clk),
        .i_req     (req),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cfg_n <= 5'd8;
            r_cfg_g <= 3'd2;
            r_px    <= '0;
            r_py    <= '0;
            r_pz    <= '0;
            r_slot  <= '0;
            r_si    <= '0;
            r_sj    <= '0;
            r_sk    <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we && (i_cfg_index == REG_INTERIOR || i_cfg_index == REG_GHOST)) begin
                if (i_cfg_index == REG_INTERIOR) begin
                    r_cfg_n <= i_cfg_data;
                end else begin
                    r_cfg_g <= i_cfg_data[2:0];
                end
                r_px   <= '0;
                r_py   <= '0;
                r_pz   <= '0;
                r_slot <= '0;
            end else if (accept) begin
                if (ex + 1'b1 >= side) begin
                    r_px <= '0;
                    if (ey + 1'b1 >= side) begin
                        r_py <= '0;
                        if (ez + 1'b1 >= side) begin
                            r_pz   <= '0;
                            r_slot <= '0;
                        end else begin
                            r_pz   <= ez + 1'b1;
                            r_slot <= (eslot == SLOT_W'(RING_PLANES - 1)) ? '0 : eslot + 1'b1;
                        end
                    end else begin
                        r_py <= ey + 1'b1;
                        r_pz <= ez;
                        r_slot <= eslot;
                    end
                end else begin
                    r_px <= ex + 1'b1;
                    r_py <= ey;
                    r_pz <= ez;
                    r_slot <= eslot;
                end
            end
            if (rd_en) begin
                if (r_si == TAP_W'(LAST_TAP)) begin
                    r_si <= '0;
                    if (r_sj == TAP_W'(LAST_TAP)) begin
                        r_sj <= '0;
                        r_sk <= (r_sk == TAP_W'(LAST_TAP)) ? '0 : r_sk + 1'b1;
                    end else begin
                        r_sj <= r_sj + 1'b1;
                    end
                end else begin
                    r_si <= r_si + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cx    <= ex;
            r_cy    <= ey;
            r_cz    <= ez;
            r_cslot <= eslot;
        end
    end

    // multiply pipeline
    logic [TAP_W-1:0] r_i1, r_j1, r_k1, r_j2, r_k2, r_k3;
    logic signed [43:0] r_mx [2];
    logic signed [55:0] r_my [4];
    logic signed [ACC_W-1:0] r_mz [CHILDREN];
    logic signed [ACC_W-1:0] r_acc [CHILDREN];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= rd_en;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i1 <= r_si;
        r_j1 <= r_sj;
        r_k1 <= r_sk;
        r_j2 <= r_j1;
        r_k2 <= r_k1;
        r_k3 <= r_k2;
        for (int o = 0; o < 2; o++) begin
            r_mx[o] <= 44'($signed(rd_data)) * 44'(lp3_weight(o[0], r_i1));
        end
        for (int o = 0; o < 4; o++) begin
            r_my[o] <= 56'(r_mx[o % 2]) * 56'(lp3_weight(o[1], r_j2));
        end
        for (int o = 0; o < CHILDREN; o++) begin
            r_mz[o] <= ACC_W'(r_my[o % 4]) * ACC_W'(lp3_weight(o[2], r_k3));
        end
        for (int o = 0; o < CHILDREN; o++) begin
            if (accept) begin
                r_acc[o] <= '0;
            end else if (r_v4) begin
                r_acc[o] <= r_acc[o] + r_mz[o];
            end
        end
    end

    // round half up by 2^33 and saturate
    logic signed [ACC_W:0] rsum;
    logic signed [ACC_W-33:0] rq;
    logic [31:0] fine;
    logic [2:0] csel;
    assign csel = r_child[2:0];
    assign rsum = (ACC_W+1)'(r_acc[csel]) + ((ACC_W+1)'(1) <<< 32);
    assign rq   = rsum[ACC_W:33];
    always_comb begin
        if (rq > (ACC_W-32)'(32'sh7fffffff)) begin
            fine = 32'h7fffffff;
        end else if (rq < -(ACC_W-32)'(64'sh80000000)) begin
            fine = 32'h80000000;
        end else begin
            fine = rq[31:0];
        end
    end

    logic r_out_valid, r_last;
    logic [31:0] r_val;
    logic [5:0] r_fx, r_fy, r_fz;
    logic [5:0] bx, by, bz;
    assign bx = 6'({r_cx, 1'b0}) - 6'd4 - 6'(cg);
    assign by = 6'({r_cy, 1'b0}) - 6'd4 - 6'(cg);
    assign bz = 6'({r_cz, 1'b0}) - 6'd4 - 6'(cg);
    assign load_out = (r_state == S_EMIT) && (r_child != CHILD_W'(CHILDREN)) &&
                      (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_child     <= '0;
        end else begin
            if (r_state == S_DRAIN) begin
                r_child <= '0;
            end else if (load_out) begin
                r_child <= r_child + 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_val  <= fine;
            r_fx   <= bx + 6'(csel[0]);
            r_fy   <= by + 6'(csel[1]);
            r_fz   <= bz + 6'(csel[2]);
            r_last <= (csel == 3'd7);
        end
    end

    assign o_valid      = r_out_valid;
    assign o_fine_value = r_val;
    assign o_fine_x     = r_fx;
    assign o_fine_y     = r_fy;
    assign o_fine_z     = r_fz;
    assign o_last_child = r_last;

    `LP3_CHECK(a_emit_drained, (r_state == S_EMIT) |-> (!r_v1 && !r_v4), "emit before drain")
    `LP3_CHECK(a_acc_busy, r_v4 |-> (r_state == S_READ || r_state == S_DRAIN), "stray product")
    `LP3_HOLD(a_child_hold, r_state == S_EMIT && r_out_valid && i_stall, r_child, "child moved")
endmodule

[hw/rtl/lp3_ring_mem.sv]
// Plane ring storage: single-write, single-read synchronous memory.
// Depends on lp3_pkg.
module lp3_ring_mem
    import lp3_pkg::*;
(
    input  logic        i_clk,
    input  t_ring_req   i_req,
    output logic [31:0] o_rd_data
);
    logic [31:0] r_mem [RING_DEPTH];
    logic [31:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.wr_addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule
